// File: src/dns_query_name_parser_defines.svh
// Assertion macros shared by the DNS query name parser modules.
// Depends on nothing; the including module supplies clk and rst.
`ifndef DNS_QUERY_NAME_PARSER_DEFINES_SVH
`define DNS_QUERY_NAME_PARSER_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define DQNP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger in one cycle implies a condition in the next.
`define DQNP_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// File: src/dqnp_pkg.sv
// Shared types and constants for the DNS query name parser.
// Depends on nothing; imported by every module of the block.
package dqnp_pkg;

  localparam logic [7:0] HdrLen  = 8'd12;
  localparam logic [7:0] DotChar = 8'h2E;

  // Configuration register indexes
  localparam logic [7:0] REG_V4_SERVER_OFFSET = 8'd0;
  localparam logic [7:0] REG_V6_SERVER_OFFSET = 8'd1;
  localparam logic [7:0] REG_V4_DNS_OFFSET    = 8'd2;
  localparam logic [7:0] REG_V6_DNS_OFFSET    = 8'd3;

  // Parse status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_SHORT  = 3'd1;
  localparam logic [2:0] ST_UNTERM = 3'd2;
  localparam logic [2:0] ST_TYPE   = 3'd3;
  localparam logic [2:0] ST_BAD    = 3'd4;

  // Result item kinds
  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } in_item_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  name_char;
    logic [3:0]  version_seen;
    logic [15:0] query_kind;
    logic [63:0] server_high;
    logic [63:0] server_low;
    logic [7:0]  name_chars;
    logic [2:0]  parse_status;
    logic        run_last;
  } out_item_t;

  // Results of one packet byte: an optional name character, then an
  // optional summary record.
  typedef struct packed {
    logic       char_valid;
    logic [7:0] name_char;
    logic       sum_valid;
    out_item_t  summary;
  } dqnp_pair_t;

  typedef struct packed {
    logic       push;
    dqnp_pair_t pair;
  } dqnp_push_t;

endpackage

// File: src/dqnp_parse.sv
// Per-byte parse step: configuration registers, packet state and the
// combinational update that turns one byte into its results. Uses dqnp_pkg.
module dqnp_parse
  import dqnp_pkg::*;
#(
  parameter int MAX_NAME_LEN = 255
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       step,
  input  in_item_t   item,
  output dqnp_push_t result
);

  localparam logic [7:0] MaxLen = 8'(MAX_NAME_LEN);

  typedef enum logic [2:0] {
    PH_HEADER, PH_LEN, PH_BODY, PH_TYPE, PH_DONE, PH_STOP
  } phase_t;

  typedef struct packed {
    logic [15:0] pos;
    logic [3:0]  version;
    phase_t      phase;
    logic [5:0]  label_left;
    logic        first;
    logic [7:0]  name_count;
    logic [63:0] sw_high;
    logic [63:0] sw_low;
    logic [15:0] type_held;
    logic [1:0]  type_seen;
    logic [2:0]  status;
  } pstate_t;

  localparam pstate_t ResetState = '{
    pos: '0, version: '0, phase: PH_HEADER, label_left: '0, first: 1'b1,
    name_count: '0, sw_high: '0, sw_low: '0, type_held: '0, type_seen: '0,
    status: ST_OK
  };

  logic [7:0] v4_server_offset, v6_server_offset, v4_dns_offset, v6_dns_offset;
  pstate_t    state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4_server_offset <= 8'd16;
      v6_server_offset <= 8'd24;
      v4_dns_offset    <= 8'd28;
      v6_dns_offset    <= 8'd48;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_V4_SERVER_OFFSET: v4_server_offset <= cfg_data;
        REG_V6_SERVER_OFFSET: v6_server_offset <= cfg_data;
        REG_V4_DNS_OFFSET:    v4_dns_offset    <= cfg_data;
        REG_V6_DNS_OFFSET:    v6_dns_offset    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ResetState;
    end else if (step) begin
      state <= state_next;
    end
  end

  logic [7:0]  b;
  logic        is4;
  logic [7:0]  soff, doff;
  logic [15:0] k;
  logic [16:0] dns_start;
  pstate_t     s;
  logic [2:0]  st;

  always_comb begin
    b   = item.data_byte;
    s   = state;
    result = '0;
    if (state.pos == 16'd0) begin
      s.version = b[7:4];
    end
    is4  = (s.version == 4'd4);
    soff = is4 ? v4_server_offset : v6_server_offset;
    doff = is4 ? v4_dns_offset : v6_dns_offset;
    k    = state.pos - {8'd0, soff};

    // Capture the server address bytes
    if (state.pos >= {8'd0, soff}) begin
      if (is4 && k < 16'd4) begin
        s.sw_low = {32'd0, state.sw_low[23:0], b};
      end else if (!is4 && k < 16'd8) begin
        s.sw_high = {state.sw_high[55:0], b};
      end else if (!is4 && k < 16'd16) begin
        s.sw_low = {state.sw_low[55:0], b};
      end
    end

    dns_start = {9'd0, doff} + {9'd0, HdrLen};
    if (state.phase == PH_HEADER && {1'b0, state.pos} >= dns_start) begin
      s.phase = PH_LEN;
    end

    case (s.phase)
      PH_LEN: begin
        if (b == 8'd0) begin
          s.phase = PH_TYPE;
        end else if (b >= 8'd64) begin
          s.status = ST_BAD;
          s.phase  = PH_STOP;
        end else begin
          s.label_left = b[5:0];
          s.phase      = PH_BODY;
          s.first      = 1'b0;
          if (!state.first) begin
            if (state.name_count >= MaxLen) begin
              s.status = ST_BAD;
              s.phase  = PH_STOP;
            end else begin
              s.name_count           = state.name_count + 8'd1;
              result.pair.char_valid = 1'b1;
              result.pair.name_char  = DotChar;
            end
          end
        end
      end
      PH_BODY: begin
        if (state.name_count >= MaxLen) begin
          s.status = ST_BAD;
          s.phase  = PH_STOP;
        end else begin
          s.name_count           = state.name_count + 8'd1;
          result.pair.char_valid = 1'b1;
          result.pair.name_char  = b;
          s.label_left           = state.label_left - 6'd1;
          if (state.label_left == 6'd1) begin
            s.phase = PH_LEN;
          end
        end
      end
      PH_TYPE: begin
        s.type_held = {state.type_held[7:0], b};
        s.type_seen = state.type_seen + 2'd1;
        if (state.type_seen >= 2'd1) begin
          s.phase = PH_DONE;
        end
      end
      default: ;
    endcase

    if (state.pos != 16'hFFFF) begin
      s.pos = state.pos + 16'd1;
    end

    if (s.status == ST_BAD) begin
      st = ST_BAD;
    end else if (s.phase == PH_HEADER) begin
      st = ST_SHORT;
    end else if (s.phase inside {PH_LEN, PH_BODY}) begin
      st = ST_UNTERM;
    end else if (s.phase == PH_TYPE) begin
      st = ST_TYPE;
    end else begin
      st = ST_OK;
    end

    result.pair.sum_valid            = item.end_of_packet;
    result.pair.summary.item_kind    = KIND_SUMMARY;
    result.pair.summary.version_seen = s.version;
    result.pair.summary.query_kind   = (st == ST_OK) ? s.type_held : 16'd0;
    result.pair.summary.server_high  = s.sw_high;
    result.pair.summary.server_low   = s.sw_low;
    result.pair.summary.name_chars   = s.name_count;
    result.pair.summary.parse_status = st;
    result.pair.summary.run_last     = 1'b1;
    result.push = step && (result.pair.char_valid || item.end_of_packet);

    // Drop all packet state after the summary record
    state_next = item.end_of_packet ? ResetState : s;
  end

endmodule

// File: src/dqnp_queue.sv
// Two-entry result queue: holds per-byte result pairs and hands out one
// result item per transfer, name character first. Uses dqnp_pkg.
`include "dns_query_name_parser_defines.svh"

module dqnp_queue
  import dqnp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dqnp_push_t push_in,
  output logic       can_push,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  dqnp_pair_t slot [2];
  logic [1:0] count;
  dqnp_pair_t slot_next [2];
  logic [1:0] count_next;
  logic       fire, partial, pop;
  logic [1:0] wr_at;

  assign can_push  = (count < 2'd2);
  assign out_valid = (count != 2'd0);
  assign fire      = out_valid && out_ready;
  assign partial   = fire && slot[0].char_valid && slot[0].sum_valid;
  assign pop       = fire && !partial;

  always_comb begin
    out_data = '0;
    if (slot[0].char_valid) begin
      out_data.item_kind = KIND_CHAR;
      out_data.name_char = slot[0].name_char;
    end else begin
      out_data = slot[0].summary;
    end
  end

  always_comb begin
    slot_next  = slot;
    count_next = count;
    if (partial) begin
      slot_next[0].char_valid = 1'b0;
    end
    if (pop) begin
      slot_next[0] = slot[1];
      count_next   = count - 2'd1;
    end
    wr_at = count - {1'b0, pop};
    if (push_in.push) begin
      if (wr_at == 2'd0) begin
        slot_next[0] = push_in.pair;
      end else begin
        slot_next[1] = push_in.pair;
      end
      count_next = count_next + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    slot[0] <= slot_next[0];
    slot[1] <= slot_next[1];
  end

  `DQNP_ASSERT_ALWAYS(a_count_bound, count <= 2'd2, "result queue count out of range")
  `DQNP_ASSERT_ALWAYS(a_head_nonempty, !out_valid || slot[0].char_valid || slot[0].sum_valid,
                      "head entry holds no result")
  `DQNP_ASSERT_ALWAYS(a_no_overflow, !push_in.push || can_push, "push into full result queue")
  `DQNP_ASSERT_NEXT(a_summary_follows, partial,
                    out_valid && !slot[0].char_valid && slot[0].sum_valid,
                    "summary lost after name character")

endmodule

// File: src/dns_query_name_parser.sv
// DNS query name parser top level: input register, per-byte parse step and
// result queue. Uses dqnp_pkg, dqnp_parse and dqnp_queue.
//
// Usage: feed a captured IPv4/IPv6 UDP/DNS packet on in_data one byte per
// transfer (valid/ready), marking its last byte with end_of_packet. Each
// question name character (and a '.' between labels) leaves on out_data as
// a name-character item; the last byte of the packet also yields a summary
// record with version, server address, query type, name length and status.
// Offsets are set over the plain write port (cfg_we/cfg_index/cfg_data)
// while no packet is in flight; unknown indexes are ignored.
// A byte's results pass the input register, then the result queue register.
// Throughput: one byte per cycle while the queue has room; a final byte
// with both a character and the summary yields two output items, which the
// two-entry result queue absorbs and then throttles in_ready. in_ready comes
// from registered state only: input register valid and queue occupancy.
// Stalls: when out_ready is low the queue fills and in_ready drops; nothing
// is lost. Reset (rst, synchronous) empties the pipeline, restores the
// default offsets (16, 24, 28, 48) and starts a fresh packet.
`include "dns_query_name_parser_defines.svh"

module dns_query_name_parser
  import dqnp_pkg::*;
#(
  parameter int MAX_NAME_LEN = 255
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic       s1_valid;
  in_item_t   s1_item;
  logic       can_push;
  logic       step;
  dqnp_push_t push_bus;

  // Advance the held byte into the parser whenever the queue has room
  assign step     = s1_valid && can_push;
  assign in_ready = !s1_valid || can_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Hold the payload while the byte waits for queue space
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  dqnp_parse #(
    .MAX_NAME_LEN(MAX_NAME_LEN)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .step     (step),
    .item     (s1_item),
    .result   (push_bus)
  );

  dqnp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_in  (push_bus),
    .can_push (can_push),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  `DQNP_ASSERT_ALWAYS(a_push_only_on_step, !push_bus.push || step,
                      "result produced without a parse step")
  `DQNP_ASSERT_NEXT(a_byte_held_on_stall, s1_valid && !can_push,
                    s1_valid && $stable(s1_item), "held byte changed while stalled")

endmodule
